// File: hdl/piece_table_engine_assert.svh
// assertion macros for the piece table engine
`ifndef PIECE_TABLE_ENGINE_ASSERT_SVH
`define PIECE_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define PTE_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("piece table engine check failed");

// next-cycle implication
`define PTE_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("piece table engine check failed");

`endif

// File: hdl/pte_pkg.sv
// shared types and constants of the piece table engine
`default_nettype none

package pte_pkg;

	localparam int FIELD_W = 24;
	localparam int TOTAL_W = 7;

	localparam logic [1:0] ADDR_ORIG = 2'd0;

	typedef enum logic [1:0] {
		OP_RESET  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_LOCATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TABLE_FULL = 2'd1,
		ST_ADD_FULL   = 2'd2,
		ST_PAST_END   = 2'd3
	} sta_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_WALK,
		ACT_DECIDE,
		ACT_SH_RD,
		ACT_SHIFT,
		ACT_PATCH,
		ACT_CP_RD,
		ACT_COMPACT
	} act_t;

	typedef enum logic [1:0] {
		PLAN_DONE,
		PLAN_SHIFT,
		PLAN_PATCH,
		PLAN_COMPACT
	} plan_t;

	typedef struct packed {
		logic               src;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] len;
	} entry_t;

	typedef struct packed {
		act_t act;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic  walk_done;
		plan_t plan;
		logic  shift_done;
		logic  patch_last;
		logic  compact_done;
	} stat_t;

endpackage

`default_nettype wire

// File: hdl/pte_if.sv
// request and response channel interfaces
`default_nettype none

interface pte_req_if import pte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [FIELD_W-1:0] position;
	logic [FIELD_W-1:0] length;

	modport source (output valid, opcode, position, length, input ready);
	modport sink (input valid, opcode, position, length, output ready);
endinterface

interface pte_rsp_if import pte_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic               src;
	logic [FIELD_W-1:0] address;
	logic [FIELD_W-1:0] add_offset;
	logic [TOTAL_W-1:0] piece_total;
	logic [FIELD_W-1:0] text_size;

	modport source (output valid, status, src, address, add_offset, piece_total, text_size,
		input ready);
	modport sink (input valid, status, src, address, add_offset, piece_total, text_size,
		output ready);
endinterface

`default_nettype wire

// File: hdl/pte_ctrl.sv
// sequencing state machine of the piece table engine
`default_nettype none

module pte_ctrl import pte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_fire,
	input  logic  out_free,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  ready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_DECIDE,
		S_SH_RD,
		S_SHIFT,
		S_PATCH,
		S_CP_RD,
		S_COMPACT,
		S_DELIVER
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign ready = ready_q;

	always_comb begin
		cmd.act = ACT_NONE;
		cmd.publish = 1'b0;
		case (state_q)
			S_IDLE:    if (req_fire) cmd.act = ACT_LOAD;
			S_WALK:    cmd.act = ACT_WALK;
			S_DECIDE:  cmd.act = ACT_DECIDE;
			S_SH_RD:   cmd.act = ACT_SH_RD;
			S_SHIFT:   cmd.act = ACT_SHIFT;
			S_PATCH:   cmd.act = ACT_PATCH;
			S_CP_RD:   cmd.act = ACT_CP_RD;
			S_COMPACT: cmd.act = ACT_COMPACT;
			S_DELIVER: cmd.publish = out_free;
			default:   cmd.act = ACT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_WALK;
						ready_q <= 1'b0;
					end
				end
				S_WALK: if (stat.walk_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					case (stat.plan)
						PLAN_SHIFT:   state_q <= S_SH_RD;
						PLAN_PATCH:   state_q <= S_PATCH;
						PLAN_COMPACT: state_q <= S_CP_RD;
						default:      state_q <= S_DELIVER;
					endcase
				end
				S_SH_RD:   state_q <= S_SHIFT;
				S_SHIFT:   if (stat.shift_done) state_q <= S_PATCH;
				S_PATCH:   if (stat.patch_last) state_q <= S_DELIVER;
				S_CP_RD:   state_q <= S_COMPACT;
				S_COMPACT: if (stat.compact_done) state_q <= S_DELIVER;
				S_DELIVER: begin
					if (out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/pte_datapath.sv
// piece memory, walk/shift/compact pointers and result registers
`default_nettype none

module pte_datapath import pte_pkg::*; #(
	parameter int PIECE_DEPTH   = 64,
	parameter int ADD_CAPACITY  = 16777215,
	parameter int POSITION_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         opcode,
	input  logic [FIELD_W-1:0] position,
	input  logic [FIELD_W-1:0] length,
	input  logic [FIELD_W-1:0] original_length,
	output logic [1:0]         status,
	output logic               source,
	output logic [FIELD_W-1:0] address,
	output logic [FIELD_W-1:0] add_offset,
	output logic [TOTAL_W-1:0] piece_total,
	output logic [FIELD_W-1:0] text_size
);

	localparam int AW = $clog2(PIECE_DEPTH);
	localparam int IW = $clog2(PIECE_DEPTH + 1);
	localparam int TW = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;
	localparam int CW = TW + 1;
	localparam logic [CW-1:0] TEXT_MAX = CW'((64'd1 << POSITION_BITS) - 64'd1);
	localparam logic [FIELD_W:0] ADD_CAP = (FIELD_W + 1)'(ADD_CAPACITY);
	localparam logic [IW:0] DEPTH_C = (IW + 1)'(PIECE_DEPTH);

	entry_t mem_q [PIECE_DEPTH];
	entry_t rd_q;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	entry_t          wr_data;

	op_t                op_q;
	logic [FIELD_W-1:0] pos_q;
	logic [FIELD_W-1:0] len_q;
	logic [IW-1:0]      used_q;
	logic [FIELD_W-1:0] fill_q;
	logic [TW-1:0]      total_q;
	logic [IW-1:0]      idx_q;
	logic [CW-1:0]      cur_q;
	logic [IW-1:0]      hit_q;
	logic               found_q;
	logic [CW-1:0]      hcur_q;
	logic [CW-1:0]      hend_q;
	entry_t             he_q;
	logic [FIELD_W-1:0] off_q;
	logic [IW-1:0]      w_q;
	logic [IW-1:0]      ins_q;
	logic               k2_q;
	logic               split_q;
	logic [1:0]         pstep_q;
	sta_t               sta_q;
	logic               src_q;
	logic [FIELD_W-1:0] addr_q;
	logic [FIELD_W-1:0] aoff_q;

	entry_t             e;
	logic [CW-1:0]      pos_x;
	logic [CW-1:0]      de;
	logic [CW-1:0]      ends;
	logic [CW-1:0]      tot_x;
	logic [CW-1:0]      clip;
	logic [CW-1:0]      removed;
	logic [CW-1:0]      tsum;
	logic [FIELD_W:0]   add_sum;
	logic               hit_cond;
	logic               ins_split;
	logic               del_split;
	logic [IW-1:0]      ins_pt;
	logic               full_ins;
	logic               full_del;
	plan_t              plan_c;
	sta_t               sta_c;
	logic               outside;
	logic               emit;
	entry_t             keep;
	logic [FIELD_W-1:0] skip;

	assign e       = rd_q;
	assign pos_x   = CW'(pos_q);
	assign de      = pos_x + CW'(len_q);
	assign ends    = cur_q + CW'(e.len);
	assign tot_x   = CW'(total_q);
	assign clip    = (de < tot_x) ? de : tot_x;
	assign removed = clip - pos_x;
	assign tsum    = tot_x + CW'(len_q);
	assign add_sum = {1'b0, fill_q} + {1'b0, len_q};
	assign skip    = FIELD_W'(de - hcur_q);

	// insert stops at the first piece reaching the position, the others past it
	assign hit_cond  = (op_q == OP_INSERT) ? (ends >= pos_x) : (ends > pos_x);
	assign ins_split = found_q && (off_q != '0) && (off_q < he_q.len);
	assign del_split = found_q && (hcur_q < pos_x) && (hend_q > de);
	assign ins_pt    = hit_q + IW'(found_q && (off_q != '0));
	assign full_ins  = ({1'b0, used_q} + (IW + 1)'(1) + (IW + 1)'(ins_split)) > DEPTH_C;
	assign full_del  = ({1'b0, used_q} + (IW + 1)'(1)) > DEPTH_C;

	always_comb begin
		plan_c = PLAN_DONE;
		sta_c = ST_OK;
		case (op_q)
			OP_INSERT: begin
				if (len_q != '0) begin
					if (full_ins) sta_c = ST_TABLE_FULL;
					else if (add_sum > ADD_CAP) sta_c = ST_ADD_FULL;
					else if (tsum > TEXT_MAX) sta_c = ST_ADD_FULL;
					else if (ins_pt == used_q) plan_c = PLAN_PATCH;
					else plan_c = PLAN_SHIFT;
				end
			end
			OP_DELETE: begin
				if (len_q != '0 && found_q) begin
					if (del_split) begin
						if (full_del) sta_c = ST_TABLE_FULL;
						else if (hit_q + IW'(1) == used_q) plan_c = PLAN_PATCH;
						else plan_c = PLAN_SHIFT;
					end else begin
						plan_c = PLAN_COMPACT;
					end
				end
			end
			OP_LOCATE: if (!found_q) sta_c = ST_PAST_END;
			default: sta_c = ST_OK;
		endcase
	end

	// at most one surviving part per piece when no piece holds the whole range
	always_comb begin
		outside = (ends <= pos_x) || (cur_q >= de);
		emit = 1'b1;
		keep = e;
		if (!outside) begin
			if (cur_q < pos_x) begin
				keep.len = FIELD_W'(pos_x - cur_q);
			end else if (ends > de) begin
				keep.start = e.start + FIELD_W'(de - cur_q);
				keep.len = FIELD_W'(ends - de);
			end else begin
				emit = 1'b0;
			end
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = e;
		rd_addr = AW'(idx_q);
		case (cmd.act)
			ACT_LOAD: rd_addr = '0;
			ACT_WALK: rd_addr = AW'(idx_q + IW'(1));
			ACT_DECIDE: begin
				if (op_q == OP_RESET && original_length != '0) begin
					wr_en = 1'b1;
					wr_data = '{src: 1'b0, start: '0, len: original_length};
				end
			end
			ACT_SHIFT: begin
				wr_en = 1'b1;
				wr_addr = AW'(idx_q + (k2_q ? IW'(2) : IW'(1)));
				rd_addr = AW'(idx_q - IW'(1));
			end
			ACT_PATCH: begin
				wr_en = 1'b1;
				if (op_q == OP_INSERT) begin
					if (split_q && pstep_q == 2'd0) begin
						wr_addr = AW'(hit_q);
						wr_data = '{src: he_q.src, start: he_q.start, len: off_q};
					end else if (!split_q || pstep_q == 2'd1) begin
						wr_addr = AW'(ins_q);
						wr_data = '{src: 1'b1, start: aoff_q, len: len_q};
					end else begin
						wr_addr = AW'(ins_q + IW'(1));
						wr_data = '{src: he_q.src, start: he_q.start + off_q,
							len: he_q.len - off_q};
					end
				end else if (pstep_q == 2'd0) begin
					wr_addr = AW'(hit_q);
					wr_data = '{src: he_q.src, start: he_q.start, len: off_q};
				end else begin
					wr_addr = AW'(ins_q);
					wr_data = '{src: he_q.src, start: he_q.start + skip,
						len: FIELD_W'(hend_q - de)};
				end
			end
			ACT_COMPACT: begin
				rd_addr = AW'(idx_q + IW'(1));
				if (idx_q != used_q && emit) begin
					wr_en = 1'b1;
					wr_addr = AW'(w_q);
					wr_data = keep;
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	assign stat.walk_done    = (idx_q == used_q) || hit_cond;
	assign stat.plan         = plan_c;
	assign stat.shift_done   = (idx_q == ins_q);
	assign stat.patch_last   = (op_q == OP_INSERT) ? (!split_q || pstep_q == 2'd2)
		: (pstep_q == 2'd1);
	assign stat.compact_done = (idx_q == used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
			total_q <= '0;
		end else begin
			case (cmd.act)
				ACT_DECIDE: begin
					case (op_q)
						OP_RESET: begin
							used_q <= IW'(original_length != '0);
							total_q <= TW'(original_length);
						end
						OP_INSERT: begin
							if (plan_c != PLAN_DONE) begin
								used_q <= used_q + IW'(1) + IW'(ins_split);
								fill_q <= fill_q + len_q;
								total_q <= TW'(tsum);
							end
						end
						OP_DELETE: begin
							if (plan_c != PLAN_DONE) begin
								total_q <= TW'(tot_x - removed);
								if (del_split) used_q <= used_q + IW'(1);
							end
						end
						default: used_q <= used_q;
					endcase
				end
				ACT_COMPACT: if (idx_q == used_q) used_q <= w_q;
				default: used_q <= used_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.act)
			ACT_LOAD: begin
				op_q <= op_t'(opcode);
				pos_q <= position;
				len_q <= length;
				idx_q <= '0;
				cur_q <= '0;
				found_q <= 1'b0;
				hit_q <= '0;
			end
			ACT_WALK: begin
				if (idx_q == used_q) begin
					hit_q <= used_q;
				end else if (hit_cond) begin
					found_q <= 1'b1;
					hit_q <= idx_q;
					hcur_q <= cur_q;
					hend_q <= ends;
					he_q <= e;
					off_q <= FIELD_W'(pos_x - cur_q);
				end else begin
					idx_q <= idx_q + IW'(1);
					cur_q <= ends;
				end
			end
			ACT_DECIDE: begin
				sta_q <= sta_c;
				src_q <= 1'b0;
				addr_q <= '0;
				aoff_q <= fill_q;
				if (op_q == OP_LOCATE && found_q) begin
					src_q <= he_q.src;
					addr_q <= he_q.start + off_q;
				end
				pstep_q <= '0;
				split_q <= (op_q == OP_INSERT) ? ins_split : del_split;
				k2_q <= (op_q == OP_INSERT) && ins_split;
				ins_q <= (op_q == OP_INSERT) ? ins_pt : hit_q + IW'(1);
				w_q <= hit_q;
				idx_q <= (plan_c == PLAN_SHIFT) ? used_q - IW'(1) : hit_q;
				cur_q <= hcur_q;
			end
			ACT_SHIFT: idx_q <= idx_q - IW'(1);
			ACT_PATCH: pstep_q <= pstep_q + 2'd1;
			ACT_COMPACT: begin
				if (idx_q != used_q) begin
					idx_q <= idx_q + IW'(1);
					cur_q <= ends;
					if (emit) w_q <= w_q + IW'(1);
				end
			end
			default: pstep_q <= pstep_q;
		endcase
	end

	assign status      = sta_q;
	assign source      = src_q;
	assign address     = addr_q;
	assign add_offset  = aoff_q;
	assign piece_total = TOTAL_W'(used_q);
	assign text_size   = FIELD_W'(total_q);

endmodule

`default_nettype wire

// File: hdl/piece_table_engine.sv
// piece table engine top level: config port, sequencer, datapath, result register
//
//  channel | dir | fields
//  req     | in  | opcode, position, length
//  rsp     | out | status, src, address, add_offset, piece_total, text_size
//  apb     | in  | original_length at byte address 0
//
// an item's run time grows with the number of pieces in the table:
// the walk reads one entry per cycle up to the hit, then the same memory shifts or
// compacts the entries past it, one per cycle
// one item is in work at a time; the next is taken once its result sits in the output
// register, which holds it while rsp is stalled
// reset clears the piece count, add-store fill, text size and original length
`default_nettype none
`include "piece_table_engine_assert.svh"

module piece_table_engine import pte_pkg::*; #(
	parameter int PIECE_DEPTH   = 64,
	parameter int ADD_CAPACITY  = 16777215,
	parameter int POSITION_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	pte_req_if.sink     req,
	pte_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [FIELD_W-1:0] orig_q;
	logic               req_fire;
	logic               out_free;
	logic               rsp_valid_q;
	cmd_t               cmd;
	stat_t              stat;

	logic [1:0]         dp_status;
	logic               dp_source;
	logic [FIELD_W-1:0] dp_address;
	logic [FIELD_W-1:0] dp_add_offset;
	logic [TOTAL_W-1:0] dp_piece_total;
	logic [FIELD_W-1:0] dp_text_size;

	logic [1:0]         status_q;
	logic               source_q;
	logic [FIELD_W-1:0] address_q;
	logic [FIELD_W-1:0] add_offset_q;
	logic [TOTAL_W-1:0] piece_total_q;
	logic [FIELD_W-1:0] text_size_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ORIG) ? 32'(orig_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q <= '0;
		end else if (psel && penable && pwrite && paddr == ADDR_ORIG) begin
			orig_q <= pwdata[FIELD_W-1:0];
		end
	end

	assign req_fire = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	pte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_fire (req_fire),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.ready    (req.ready)
	);

	pte_datapath #(
		.PIECE_DEPTH   (PIECE_DEPTH),
		.ADD_CAPACITY  (ADD_CAPACITY),
		.POSITION_BITS (POSITION_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.opcode          (req.opcode),
		.position        (req.position),
		.length          (req.length),
		.original_length (orig_q),
		.status          (dp_status),
		.source          (dp_source),
		.address         (dp_address),
		.add_offset      (dp_add_offset),
		.piece_total     (dp_piece_total),
		.text_size       (dp_text_size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status_q <= dp_status;
			source_q <= dp_source;
			address_q <= dp_address;
			add_offset_q <= dp_add_offset;
			piece_total_q <= dp_piece_total;
			text_size_q <= dp_text_size;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.src         = source_q;
	assign rsp.address     = address_q;
	assign rsp.add_offset  = add_offset_q;
	assign rsp.piece_total = piece_total_q;
	assign rsp.text_size   = text_size_q;

	`PTE_NEXT(a_busy_after_accept, req_fire, !req.ready)
	`PTE_IMP(a_no_result_overwrite, cmd.publish, !rsp_valid_q || rsp.ready)
	`PTE_IMP(a_past_end_clean, rsp.valid && rsp.status == ST_PAST_END, !rsp.src && rsp.address == '0)

endmodule

`default_nettype wire
